// File: hdl/grt3_pkg.sv
// Shared types, constants and helpers for the 3D grid ray walker.
// No dependencies; imported by grid_ray_traversal_3d_core.
package grt3_pkg;

  localparam int GRID_X     = 16;
  localparam int GRID_Y     = 16;
  localparam int GRID_Z     = 16;
  localparam int MAX_VISITS = 64;

  localparam int CNT_W  = $clog2(MAX_VISITS + 1);
  localparam int NUM_W  = 49;   // divider dividend magnitude
  localparam int DEN_W  = 32;   // divider divisor
  localparam int QS_W   = 50;   // signed quotient
  localparam int CELL_W = 34;
  localparam int STEP_W = 51;
  localparam int T_W    = 64;
  localparam int IDX_W  = 12;
  localparam int LIN_W  = 24;

  localparam logic [T_W-1:0] TIME_INF = 64'h4000_0000_0000_0000;
  localparam logic [30:0]    SIZE_RST = 31'd65536;

  // configuration register indexes
  localparam logic [2:0] REG_ORG_X  = 3'd0;
  localparam logic [2:0] REG_ORG_Y  = 3'd1;
  localparam logic [2:0] REG_ORG_Z  = 3'd2;
  localparam logic [2:0] REG_SIZE_X = 3'd3;
  localparam logic [2:0] REG_SIZE_Y = 3'd4;
  localparam logic [2:0] REG_SIZE_Z = 3'd5;

  // division kinds run per axis
  localparam logic [1:0] OP_CELL = 2'd0;
  localparam logic [1:0] OP_END  = 2'd1;
  localparam logic [1:0] OP_CT   = 2'd2;
  localparam logic [1:0] OP_T    = 2'd3;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL   = 8'b0000_0010,
    ST_LOAD  = 8'b0000_0100,
    ST_DIV   = 8'b0000_1000,
    ST_STORE = 8'b0001_0000,
    ST_STEPS = 8'b0010_0000,
    ST_CHK   = 8'b0100_0000,
    ST_WALK  = 8'b1000_0000
  } state_t;

  // saturate a wide cell coordinate to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [CELL_W-1:0] v);
    logic signed [15:0] r;
    if (v > CELL_W'(signed'(32767)))       r = 16'sh7FFF;
    else if (v < CELL_W'(signed'(-32768))) r = 16'sh8000;
    else                                   r = v[15:0];
    return r;
  endfunction

  function automatic logic in_range(input logic signed [CELL_W-1:0] v, input int lim);
    return (v >= 0) && (v < CELL_W'(lim));
  endfunction

endpackage

// File: hdl/grid_ray_traversal_3d_core.sv
// Top level of the 3D grid ray walker (Amanatides-Woo DDA, Q16.16).
// Depends on grt3_pkg. One shared restoring divider does all per-ray setup divisions.
//
// A ray is taken when in_ready is high; the block then stays busy until the
// ray's last cell has been handed over. Setup runs per axis a multiply
// step and four divisions on the single shared one-bit-per-cycle divider
// (start cell, end cell, crossing time, first boundary time), each framed
// by a load and a store state, plus a step-count state; then the step
// counts of all axes are checked. If one is negative the ray ends with no
// cells; else the walk emits one cell per cycle while out_ready stays high,
// at most MAX_VISITS cells. The output register lets a new ray be taken
// while the final cell of the previous one still waits.
module grid_ray_traversal_3d_core
  import grt3_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_ray_start_x,
  input  logic signed [31:0] in_ray_start_y,
  input  logic signed [31:0] in_ray_start_z,
  input  logic signed [31:0] in_ray_dir_x,
  input  logic signed [31:0] in_ray_dir_y,
  input  logic signed [31:0] in_ray_dir_z,
  input  logic [30:0]        in_max_distance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_cell_x,
  output logic signed [15:0] out_cell_y,
  output logic signed [15:0] out_cell_z,
  output logic               out_inside_grid,
  output logic [IDX_W-1:0]   out_cell_index,
  output logic               out_truncated,
  output logic               out_last
);

  // configuration
  logic signed [31:0] org_r  [3];
  logic        [30:0] size_r [3];

  // latched ray
  logic signed [31:0] st_r [3];
  logic signed [31:0] dir_r[3];
  logic        [30:0] md_r;

  // sequencer
  state_t      state_r, state_nxt;
  logic [1:0]  ax_r;
  logic [1:0]  op_r;
  logic [5:0]  bit_r;

  // setup datapath
  logic signed [62:0]       prod_r;
  logic [NUM_W-1:0]         q_r;
  logic [DEN_W-1:0]         den_r;
  logic [DEN_W-1:0]         rem_r;
  logic                     neg_r;
  logic [30:0]              r_r;
  logic signed [QS_W-1:0]   ec_r;

  // walk state
  logic signed [CELL_W-1:0] cell_r [3];
  logic signed [STEP_W-1:0] steps_r[3];
  logic [T_W-1:0]           t_r    [3];
  logic [T_W-1:0]           ct_r   [3];
  logic [CNT_W-1:0]         n_r;

  // output register
  logic               out_valid_r;
  logic signed [15:0] ox_r, oy_r, oz_r;
  logic               oin_r, otr_r, olast_r;
  logic [IDX_W-1:0]   oidx_r;

  logic accept;
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // configuration writes; a zero cell size is stored as 1 (one LSB)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i]  <= '0;
        size_r[i] <= SIZE_RST;
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ORG_X:  org_r[0]  <= cfg_wdata;
        REG_ORG_Y:  org_r[1]  <= cfg_wdata;
        REG_ORG_Z:  org_r[2]  <= cfg_wdata;
        REG_SIZE_X: size_r[0] <= (cfg_wdata[30:0] == '0) ? 31'd1 : cfg_wdata[30:0];
        REG_SIZE_Y: size_r[1] <= (cfg_wdata[30:0] == '0) ? 31'd1 : cfg_wdata[30:0];
        REG_SIZE_Z: size_r[2] <= (cfg_wdata[30:0] == '0) ? 31'd1 : cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // current axis operands
  logic signed [31:0] st_a, dir_a, org_a;
  logic        [30:0] sz_a;
  logic        [31:0] absdir;
  assign st_a   = st_r[ax_r];
  assign dir_a  = dir_r[ax_r];
  assign org_a  = org_r[ax_r];
  assign sz_a   = size_r[ax_r];
  assign absdir = dir_a[31] ? 32'(-dir_a) : dir_a;

  // dividend and divisor for the next division
  logic signed [32:0]     d_s;
  logic signed [46:0]     psh;
  logic signed [47:0]     end_s;
  logic signed [48:0]     e_s;
  logic signed [QS_W-1:0] num_s, num_mag;
  logic        [30:0]     rem_t;
  always_comb begin
    d_s   = 33'(st_a) - 33'(org_a);
    psh   = prod_r[62:16];
    end_s = 48'(st_a) + 48'(psh);
    e_s   = 49'(end_s) - 49'(org_a);
    rem_t = (dir_a > 0) ? (sz_a - r_r) : r_r;
    case (op_r)
      OP_CELL: num_s = QS_W'(d_s);
      OP_END:  num_s = QS_W'(e_s);
      OP_CT:   num_s = {3'b000, sz_a, 16'h0000};
      OP_T:    num_s = {3'b000, rem_t, 16'h0000};
      default: num_s = '0;
    endcase
    num_mag = num_s[QS_W-1] ? -num_s : num_s;
  end

  // one restoring-division bit
  logic [DEN_W+1:0] trial;
  assign trial = {1'b0, rem_r, q_r[NUM_W-1]} - {2'b00, den_r};

  // signed floor result of the finished division
  logic signed [QS_W-1:0] qf;
  always_comb begin
    if (!neg_r)              qf = {1'b0, q_r};
    else if (rem_r != '0)    qf = ~{1'b0, q_r};
    else                     qf = -{1'b0, q_r};
  end

  // walk: pick the axis with the smallest boundary time
  logic [1:0]               wax;
  logic                     ended, wlast;
  logic signed [CELL_W-1:0] cx, cy, cz;
  logic [LIN_W-1:0]         lin;
  logic                     in_grid;
  logic                     emit;
  always_comb begin
    if (t_r[0] <= t_r[1] && t_r[0] <= t_r[2])      wax = 2'd0;
    else if (t_r[1] <= t_r[0] && t_r[1] <= t_r[2]) wax = 2'd1;
    else                                           wax = 2'd2;
    ended   = (steps_r[wax] == '0);
    wlast   = ended || (n_r == CNT_W'(MAX_VISITS - 1));
    cx      = cell_r[0];
    cy      = cell_r[1];
    cz      = cell_r[2];
    in_grid = in_range(cx, GRID_X) && in_range(cy, GRID_Y) && in_range(cz, GRID_Z);
    lin     = LIN_W'(cx) * LIN_W'(GRID_Y * GRID_Z) + LIN_W'(cy) * LIN_W'(GRID_Z)
              + LIN_W'(cz);
    emit    = (state_r == ST_WALK) && (!out_valid_r || out_ready);
  end

  logic steps_neg;
  assign steps_neg = steps_r[0][STEP_W-1] || steps_r[1][STEP_W-1] || steps_r[2][STEP_W-1];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_DIV;
      ST_DIV:   if (bit_r == '0) state_nxt = ST_STORE;
      ST_STORE: state_nxt = (op_r == OP_T) ? ST_STEPS : ST_LOAD;
      ST_STEPS: state_nxt = (ax_r == 2'd2) ? ST_CHK : ST_MUL;
      ST_CHK:   state_nxt = steps_neg ? ST_IDLE : ST_WALK;
      ST_WALK:  if (emit && wlast) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ax_r    <= '0;
      op_r    <= OP_CELL;
      bit_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          ax_r <= '0;
          op_r <= OP_CELL;
          n_r  <= '0;
        end
        ST_LOAD:  bit_r <= 6'(NUM_W - 1);
        ST_DIV:   bit_r <= bit_r - 6'd1;
        ST_STORE: op_r  <= op_r + 2'd1;
        ST_STEPS: ax_r  <= ax_r + 2'd1;
        ST_WALK:  if (emit) n_r <= n_r + CNT_W'(1);
        default: ;
      endcase
    end
  end

  // datapath registers
  logic signed [STEP_W-1:0] diff;
  assign diff = STEP_W'(ec_r) - STEP_W'(cell_r[ax_r]);

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (accept) begin
        st_r[0]  <= in_ray_start_x;
        st_r[1]  <= in_ray_start_y;
        st_r[2]  <= in_ray_start_z;
        dir_r[0] <= in_ray_dir_x;
        dir_r[1] <= in_ray_dir_y;
        dir_r[2] <= in_ray_dir_z;
        md_r     <= in_max_distance;
      end
      ST_MUL: prod_r <= dir_a * $signed({1'b0, md_r});
      ST_LOAD: begin
        q_r   <= num_mag[NUM_W-1:0];
        neg_r <= num_s[QS_W-1];
        rem_r <= '0;
        den_r <= (op_r == OP_CELL || op_r == OP_END) ? {1'b0, sz_a} : absdir;
      end
      ST_DIV: begin
        if (!trial[DEN_W+1]) begin
          rem_r <= trial[DEN_W-1:0];
          q_r   <= {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DEN_W-2:0], q_r[NUM_W-1]};
          q_r   <= {q_r[NUM_W-2:0], 1'b0};
        end
      end
      ST_STORE: begin
        case (op_r)
          OP_CELL: begin
            cell_r[ax_r] <= qf[CELL_W-1:0];
            if (!neg_r)            r_r <= rem_r[30:0];
            else if (rem_r != '0)  r_r <= sz_a - rem_r[30:0];
            else                   r_r <= '0;
          end
          OP_END: ec_r <= qf;
          OP_CT:  ct_r[ax_r] <= (dir_a == '0) ? TIME_INF : T_W'(q_r);
          OP_T:   t_r[ax_r]  <= (dir_a == '0) ? TIME_INF : T_W'(q_r);
          default: ;
        endcase
      end
      ST_STEPS: begin
        if (dir_a == '0)     steps_r[ax_r] <= '0;
        else if (dir_a > 0)  steps_r[ax_r] <= diff;
        else                 steps_r[ax_r] <= -diff;
      end
      ST_WALK: if (emit) begin
        t_r[wax]     <= t_r[wax] + ct_r[wax];
        cell_r[wax]  <= dir_r[wax][31] ? cell_r[wax] - CELL_W'(1)
                                       : cell_r[wax] + CELL_W'(1);
        steps_r[wax] <= steps_r[wax] - STEP_W'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ox_r    <= sat16(cx);
      oy_r    <= sat16(cy);
      oz_r    <= sat16(cz);
      oin_r   <= in_grid;
      oidx_r  <= in_grid ? lin[IDX_W-1:0] : '0;
      otr_r   <= wlast && !ended;
      olast_r <= wlast;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_x      = ox_r;
  assign out_cell_y      = oy_r;
  assign out_cell_z      = oz_r;
  assign out_inside_grid = oin_r;
  assign out_cell_index  = oidx_r;
  assign out_truncated   = otr_r;
  assign out_last        = olast_r;

  // checks
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_VISITS))
    else $error("visit count above cap");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_last)
    else $error("truncated result not marked last");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_MUL && !in_ready)
    else $error("ray accepted but setup not started");

endmodule
